[hw/rtl/sta_pkg.sv]
package sta_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int OPERATION_W  = 3;
    localparam int TERM_INDEX_W = 16;
    localparam int COEF_W       = 32;
    localparam int COUNT_OUT_W  = 6;
    localparam int STATUS_W     = 2;

    // Operation codes.
    typedef enum logic [OPERATION_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_NEGATE = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_SAT  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // Saturating arithmetic result.
    typedef struct packed {
        logic              sat;
        logic [COEF_W-1:0] value;
    } sat_result_t;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // Signed add that clips to the two's complement range.
    function automatic sat_result_t sat_add(input logic [COEF_W-1:0] a,
                                            input logic [COEF_W-1:0] b);
        logic [COEF_W:0] sum;
        sat_result_t     res;
        sum = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        if (sum[COEF_W] != sum[COEF_W-1]) begin
            res.sat   = 1'b1;
            res.value = sum[COEF_W] ? COEF_MIN : COEF_MAX;
        end else begin
            res.sat   = 1'b0;
            res.value = sum[COEF_W-1:0];
        end
        return res;
    endfunction

    // Negation; the most negative value clips to the most positive.
    function automatic sat_result_t sat_neg(input logic [COEF_W-1:0] a);
        sat_result_t res;
        if (a == COEF_MIN) begin
            res.sat   = 1'b1;
            res.value = COEF_MAX;
        end else begin
            res.sat   = 1'b0;
            res.value = (~a) + COEF_W'(1);
        end
        return res;
    endfunction

endpackage

[hw/rtl/sta_ctrl.sv]
module sta_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sta_pkg::ctrl_cmd_t  cmd
);
    import sta_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;

    // The result register can take a new result when empty or being drained.
    assign can_load = !out_valid_reg || out_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_load) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and commands.
    always_comb begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                cmd.execute = can_load;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag: set when a result is loaded, cleared when taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.execute) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/sta_datapath.sv]
module sta_datapath #(
    parameter int MAX_TERMS  = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sta_pkg::ctrl_cmd_t                  cmd,
    input  logic [sta_pkg::OPERATION_W-1:0]     operation,
    input  logic [sta_pkg::TERM_INDEX_W-1:0]    term_index,
    input  logic signed [sta_pkg::COEF_W-1:0]   coefficient_in,
    output logic signed [sta_pkg::COEF_W-1:0]   coefficient_out,
    output logic                                present,
    output logic [sta_pkg::COUNT_OUT_W-1:0]     count_out,
    output logic [sta_pkg::STATUS_W-1:0]        status
);
    import sta_pkg::*;

    localparam int KW = (INDEX_BITS < TERM_INDEX_W) ? INDEX_BITS : TERM_INDEX_W;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam logic [MAX_TERMS-1:0] ONE_VEC = MAX_TERMS'(1);

    // Term table, held as a row of entries that each compare and shift.
    logic [KW-1:0]     idx_reg   [MAX_TERMS];
    logic [KW-1:0]     idx_next  [MAX_TERMS];
    logic [COEF_W-1:0] coef_reg  [MAX_TERMS];
    logic [COEF_W-1:0] coef_next [MAX_TERMS];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    // Captured transaction and match vector.
    logic [OPERATION_W-1:0] op_reg;
    logic [KW-1:0]          key_reg;
    logic [COEF_W-1:0]      cin_reg;
    logic [MAX_TERMS-1:0]   match_reg;
    logic [MAX_TERMS-1:0]   match_next;

    // Result register.
    logic [COEF_W-1:0]      coef_out_reg;
    logic [COEF_W-1:0]      coef_out_next;
    logic                   present_reg;
    logic                   present_next;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    status_t                status_reg;
    status_t                status_next;

    logic [MAX_TERMS-1:0] first_hot;
    logic [MAX_TERMS-1:0] at_or_above;
    logic                 hit;
    logic                 full;
    logic [COEF_W-1:0]    rd_coef;
    sat_result_t          add_res;
    sat_result_t          neg_res [MAX_TERMS];
    logic                 neg_any_sat;

    // Compare the incoming index against every held entry.
    always_comb begin
        for (int i = 0; i < MAX_TERMS; i++) begin
            match_next[i] = (CW'(i) < count_reg) &&
                            (idx_reg[i] == term_index[KW-1:0]);
        end
    end

    // First match as a one-hot, and the mask of that entry and all above it.
    assign first_hot   = match_reg & (~match_reg + ONE_VEC);
    assign at_or_above = ~(first_hot - ONE_VEC);
    assign hit         = |match_reg;
    assign full        = count_reg >= CW'(MAX_TERMS);

    // Read the coefficient of the matched entry.
    always_comb begin
        rd_coef = '0;
        for (int i = 0; i < MAX_TERMS; i++) begin
            rd_coef = rd_coef | (first_hot[i] ? coef_reg[i] : '0);
        end
    end

    assign add_res = sat_add(rd_coef, cin_reg);

    // Negation of every held entry, with a saturation flag.
    always_comb begin
        neg_any_sat = 1'b0;
        for (int i = 0; i < MAX_TERMS; i++) begin
            neg_res[i] = sat_neg(coef_reg[i]);
            if ((CW'(i) < count_reg) && neg_res[i].sat) begin
                neg_any_sat = 1'b1;
            end
        end
    end

    // Table update and result for the captured operation.
    always_comb begin
        for (int i = 0; i < MAX_TERMS; i++) begin
            idx_next[i]  = idx_reg[i];
            coef_next[i] = coef_reg[i];
        end
        count_next    = count_reg;
        coef_out_next = '0;
        present_next  = 1'b0;
        status_next   = STAT_OK;
        unique case (op_reg)
            OP_CLEAR:
            begin
                count_next = '0;
            end
            OP_ADD:
            begin
                present_next = hit;
                if (cin_reg == '0) begin
                    coef_out_next = hit ? rd_coef : '0;
                end else if (hit) begin
                    coef_out_next = add_res.value;
                    status_next   = add_res.sat ? STAT_SAT : STAT_OK;
                    for (int i = 0; i < MAX_TERMS; i++) begin
                        if (first_hot[i]) begin
                            coef_next[i] = add_res.value;
                        end
                    end
                end else if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    coef_out_next = cin_reg;
                    count_next    = count_reg + CW'(1);
                    for (int i = 0; i < MAX_TERMS; i++) begin
                        if (CW'(i) == count_reg) begin
                            idx_next[i]  = key_reg;
                            coef_next[i] = cin_reg;
                        end
                    end
                end
            end
            OP_REMOVE:
            begin
                if (hit) begin
                    present_next  = 1'b1;
                    coef_out_next = rd_coef;
                    count_next    = count_reg - CW'(1);
                    // Entries from the removed one upward move down by one.
                    for (int i = 0; i < MAX_TERMS - 1; i++) begin
                        if (at_or_above[i]) begin
                            idx_next[i]  = idx_reg[i+1];
                            coef_next[i] = coef_reg[i+1];
                        end
                    end
                end
            end
            OP_LOOKUP:
            begin
                if (hit) begin
                    present_next  = 1'b1;
                    coef_out_next = rd_coef;
                end
            end
            OP_NEGATE:
            begin
                status_next = neg_any_sat ? STAT_SAT : STAT_OK;
                for (int i = 0; i < MAX_TERMS; i++) begin
                    if (CW'(i) < count_reg) begin
                        coef_next[i] = neg_res[i].value;
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Term count.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    // Table contents, captured transaction and result payload.
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            op_reg    <= operation;
            key_reg   <= term_index[KW-1:0];
            cin_reg   <= coefficient_in;
            match_reg <= match_next;
        end
        if (cmd.execute) begin
            for (int i = 0; i < MAX_TERMS; i++) begin
                idx_reg[i]  <= idx_next[i];
                coef_reg[i] <= coef_next[i];
            end
            coef_out_reg  <= coef_out_next;
            present_reg   <= present_next;
            count_out_reg <= COUNT_OUT_W'(count_next);
            status_reg    <= status_next;
        end
    end

    assign coefficient_out = coef_out_reg;
    assign present         = present_reg;
    assign count_out       = count_out_reg;
    assign status          = status_reg;

endmodule

[hw/rtl/sparse_term_accumulator_unit.sv]
// An accepted transaction is captured with its match vector, then the term
// table update loads the result register; a new transaction is taken only after
// that update, and a held result stalls the update.
// Reset (rst_n, asynchronous, active low) empties the table and the result
// register; table entries are undefined until written and need no clearing pass.
module sparse_term_accumulator_unit #(
    parameter int MAX_TERMS  = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sta_pkg::OPERATION_W-1:0]     operation,
    input  logic [sta_pkg::TERM_INDEX_W-1:0]    term_index,
    input  logic signed [sta_pkg::COEF_W-1:0]   coefficient_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sta_pkg::COEF_W-1:0]   coefficient_out,
    output logic                                present,
    output logic [sta_pkg::COUNT_OUT_W-1:0]     count_out,
    output logic [sta_pkg::STATUS_W-1:0]        status
);
    import sta_pkg::*;

    ctrl_cmd_t cmd;

    // Sequencing and result handshake.
    sta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Term table, match logic and result register.
    sta_datapath #(
        .MAX_TERMS  (MAX_TERMS),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .term_index      (term_index),
        .coefficient_in  (coefficient_in),
        .coefficient_out (coefficient_out),
        .present         (present),
        .count_out       (count_out),
        .status          (status)
    );

endmodule

[hw/rtl/sta_checker.sv]
module sta_checker #(
    parameter int MAX_TERMS = 32
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [sta_pkg::COEF_W-1:0]   coefficient_out,
    input logic                                present,
    input logic [sta_pkg::COUNT_OUT_W-1:0]     count_out,
    input logic [sta_pkg::STATUS_W-1:0]        status
);
    import sta_pkg::*;

    // A stalled result keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coefficient_out)
            && $stable(present) && $stable(count_out) && $stable(status))
    else $error("Stalled result changed before it was taken.");

    // One transaction at a time: ready drops right after an input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("Input accepted in two consecutive cycles.");

    // The reported count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (MAX_TERMS > 63) || (int'(count_out) <= MAX_TERMS))
    else $error("Reported term count exceeds the table size.");

    // A dropped term reports no coefficient, no presence and a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_FULL) |->
            !present && (coefficient_out == '0)
            && ((MAX_TERMS > 63) || (int'(count_out) == MAX_TERMS)))
    else $error("Full status with inconsistent result fields.");

endmodule

bind sparse_term_accumulator_unit sta_checker #(
    .MAX_TERMS (MAX_TERMS)
) u_sta_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .coefficient_out (coefficient_out),
    .present         (present),
    .count_out       (count_out),
    .status          (status)
);
